// ----- hw/rtl/shadow_volume_extruder_assert.svh -----
// ----------------------------------------------------------------------------
// shadow volume extruder assertion macros
// concurrent checks that compile away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef SHADOW_VOLUME_EXTRUDER_ASSERT_SVH
`define SHADOW_VOLUME_EXTRUDER_ASSERT_SVH

`ifndef SYNTHESIS
// prop must hold at every edge out of reset
`define SVX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond at one edge implies expr at the next
`define SVX_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SVX_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVX_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif

`endif

// ----- hw/rtl/svx_pkg.sv -----
// ----------------------------------------------------------------------------
// svx_pkg
// shared types, codes and helpers of the shadow volume extruder
// ----------------------------------------------------------------------------
`default_nettype none

package svx_pkg;

    localparam int IDX_W        = 13;
    localparam int CORNER_W     = 12;
    localparam int COORD_W      = 32;
    localparam int NORM_W       = 16;
    localparam int IN_TDATA_W   = 184;
    localparam int OUT_TDATA_W  = 168;
    localparam int CFG_IDX_W    = 3;
    localparam int Q_DEPTH_DEF  = 4;

    localparam int MAX_OUT_TRIS = 4096;
    localparam logic [IDX_W-1:0] TRI_CAP =
        IDX_W'((MAX_OUT_TRIS < 8191) ? MAX_OUT_TRIS : 8191);

    // request codes
    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_TRI    = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NEAR  = 2'd0;
    localparam logic [1:0] KIND_FAR   = 2'd1;
    localparam logic [1:0] KIND_TRI   = 2'd2;
    localparam logic [1:0] KIND_TOTAL = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 3'd6;

    typedef struct packed {
        logic                   we;
        logic [CFG_IDX_W-1:0]   idx;
        logic [COORD_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]                req;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic [COORD_W-1:0]        pos_z;
        logic signed [NORM_W-1:0]  norm_x;
        logic signed [NORM_W-1:0]  norm_y;
        logic signed [NORM_W-1:0]  norm_z;
        logic [CORNER_W-1:0]       corner_a;
        logic [CORNER_W-1:0]       corner_b;
        logic [CORNER_W-1:0]       corner_c;
        logic [2:0]                open_mask;
    } t_in;

    // one classified item on its way from front to back
    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_W-1:0]    slot_n;
        logic [IDX_W-1:0]    slot_f;
        logic [COORD_W-1:0]  near_x;
        logic [COORD_W-1:0]  near_y;
        logic [COORD_W-1:0]  near_z;
        logic [COORD_W-1:0]  far_x;
        logic [COORD_W-1:0]  far_y;
        logic [COORD_W-1:0]  far_z;
        logic [IDX_W-1:0]    a;
        logic [IDX_W-1:0]    b;
        logic [IDX_W-1:0]    c;
        logic [IDX_W-1:0]    fa;
        logic [IDX_W-1:0]    fb;
        logic [IDX_W-1:0]    fc;
        logic                neg;
        logic [2:0]          mask;
    } t_entry;

    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_W-1:0]    vert_slot;
        logic [COORD_W-1:0]  vx;
        logic [COORD_W-1:0]  vy;
        logic [COORD_W-1:0]  vz;
        logic [IDX_W-1:0]    tri_i0;
        logic [IDX_W-1:0]    tri_i1;
        logic [IDX_W-1:0]    tri_i2;
        logic [IDX_W-1:0]    tri_total;
        logic                last;
    } t_res;

    // signed 32-bit add, clamped to the signed range
    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0]   s;
        logic [COORD_W-1:0] r;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        r = s[COORD_W-1:0];
        if (s[COORD_W] != s[COORD_W-1]) begin
            r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/shadow_volume_extruder.sv -----
// ----------------------------------------------------------------------------
// shadow_volume_extruder
// stencil shadow volume extrusion of welded mesh data, Q16.16
// ----------------------------------------------------------------------------
// A vertex word yields a near and a far copy (2 output words), a triangle
// word yields 2 to 8 triangle words (2 caps plus 2 per open edge), a finish
// word yields one triangle total and clears the counters. The front takes a
// new word every cycle unless a full queue holds it; the back puts out one
// result word per cycle while it has an item and the output is not held,
// so the sustained rate is set by the result word counts and the single
// output register. The first result word passes the product register, then
// queue, back, output register.
// Write the registers only while the block is idle.
`default_nettype none
`include "shadow_volume_extruder_assert.svh"

module shadow_volume_extruder #(
    parameter int Q_DEPTH = svx_pkg::Q_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [svx_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [svx_pkg::COORD_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner_a, corner_b,
    // corner_c, open_mask, one pad bit
    input  logic [svx_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // vert_slot, vx, vy, vz, tri_i0, tri_i1, tri_i2, tri_total, seven pad bits
    output logic [svx_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // out_kind
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    svx_pkg::t_cfg_wr w_cfg;
    svx_pkg::t_in     w_in;
    svx_pkg::t_entry  w_push_entry, w_pop_entry;
    svx_pkg::t_res    w_res;
    logic             w_push, w_q_full, w_pop, w_q_valid;
    logic             w_out_near, w_out_far, w_out_total, w_vtx_last_ok;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    assign w_in.req       = s_axis_tuser;
    assign w_in.pos_x     = s_axis_tdata[31:0];
    assign w_in.pos_y     = s_axis_tdata[63:32];
    assign w_in.pos_z     = s_axis_tdata[95:64];
    assign w_in.norm_x    = s_axis_tdata[111:96];
    assign w_in.norm_y    = s_axis_tdata[127:112];
    assign w_in.norm_z    = s_axis_tdata[143:128];
    assign w_in.corner_a  = s_axis_tdata[155:144];
    assign w_in.corner_b  = s_axis_tdata[167:156];
    assign w_in.corner_c  = s_axis_tdata[179:168];
    assign w_in.open_mask = s_axis_tdata[182:180];

    svx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_in     (w_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    svx_queue #(
        .WIDTH ($bits(svx_pkg::t_entry)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_pop_entry)
    );

    svx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_pop_entry),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;
    assign m_axis_tdata = {7'b0, w_res.tri_total, w_res.tri_i2, w_res.tri_i1, w_res.tri_i0,
                           w_res.vz, w_res.vy, w_res.vx, w_res.vert_slot};

    assign w_out_near    = m_axis_tvalid && (m_axis_tuser == svx_pkg::KIND_NEAR);
    assign w_out_far     = m_axis_tvalid && (m_axis_tuser == svx_pkg::KIND_FAR);
    assign w_out_total   = m_axis_tvalid && (m_axis_tuser == svx_pkg::KIND_TOTAL);
    assign w_vtx_last_ok = !(w_out_near && m_axis_tlast) && !(w_out_far && !m_axis_tlast);

    `SVX_ASSERT(a_no_push_full, i_clk, i_rst_n, !(w_push && w_q_full), "push into full queue")
    `SVX_ASSERT(a_total_last, i_clk, i_rst_n, !w_out_total || m_axis_tlast, "total without last")
    `SVX_ASSERT(a_vertex_last, i_clk, i_rst_n, w_vtx_last_ok, "vertex word with wrong last")
    `SVX_ASSERT_NEXT(a_far_follows, i_clk, i_rst_n, w_out_near && m_axis_tready, w_out_far, "no far copy")

endmodule

`default_nettype wire

// ----- hw/rtl/svx_front.sv -----
// ----------------------------------------------------------------------------
// svx_front
// config registers, side test and vertex sums; pushes classified items
// ----------------------------------------------------------------------------
`default_nettype none

module svx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svx_pkg::t_cfg_wr i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  svx_pkg::t_in     i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output svx_pkg::t_entry  o_entry
);

    logic signed [31:0] r_far_x, r_far_y, r_far_z;
    logic        [31:0] r_near_x, r_near_y, r_near_z;
    logic [svx_pkg::IDX_W-1:0] r_vcount;
    logic [svx_pkg::IDX_W-1:0] r_vseen;

    logic                r_s1_valid;
    svx_pkg::t_in        r_s1;
    logic signed [47:0]  r_px, r_py, r_pz;

    logic signed [47:0]  w_px, w_py, w_pz;
    logic signed [49:0]  w_dot;
    logic                w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far_x  <= '0;
            r_far_y  <= '0;
            r_far_z  <= '0;
            r_near_x <= '0;
            r_near_y <= '0;
            r_near_z <= '0;
            r_vcount <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                svx_pkg::CFG_FAR_X:  r_far_x  <= i_cfg.data;
                svx_pkg::CFG_FAR_Y:  r_far_y  <= i_cfg.data;
                svx_pkg::CFG_FAR_Z:  r_far_z  <= i_cfg.data;
                svx_pkg::CFG_NEAR_X: r_near_x <= i_cfg.data;
                svx_pkg::CFG_NEAR_Y: r_near_y <= i_cfg.data;
                svx_pkg::CFG_NEAR_Z: r_near_z <= i_cfg.data;
                svx_pkg::CFG_VCOUNT: r_vcount <= i_cfg.data[svx_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // products are registered, the sum and sign are formed combinationally from them
    assign w_px = $signed(i_in.norm_x) * r_far_x;
    assign w_py = $signed(i_in.norm_y) * r_far_y;
    assign w_pz = $signed(i_in.norm_z) * r_far_z;

    assign w_s1_free = !r_s1_valid || !i_q_full;
    assign o_ready   = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_valid) begin
            r_s1 <= i_in;
            r_px <= w_px;
            r_py <= w_py;
            r_pz <= w_pz;
        end
    end

    assign w_dot = 50'(r_px) + 50'(r_py) + 50'(r_pz);

    assign o_push = r_s1_valid && !i_q_full && (r_s1.req != svx_pkg::REQ_NONE);

    always_comb begin
        o_entry        = '0;
        o_entry.kind   = r_s1.req;
        o_entry.slot_n = r_vseen;
        o_entry.slot_f = r_vseen + r_vcount;
        o_entry.near_x = svx_pkg::sat_add(r_near_x, r_s1.pos_x);
        o_entry.near_y = svx_pkg::sat_add(r_near_y, r_s1.pos_y);
        o_entry.near_z = svx_pkg::sat_add(r_near_z, r_s1.pos_z);
        o_entry.far_x  = svx_pkg::sat_add(r_far_x, r_s1.pos_x);
        o_entry.far_y  = svx_pkg::sat_add(r_far_y, r_s1.pos_y);
        o_entry.far_z  = svx_pkg::sat_add(r_far_z, r_s1.pos_z);
        o_entry.a      = {1'b0, r_s1.corner_a};
        o_entry.b      = {1'b0, r_s1.corner_b};
        o_entry.c      = {1'b0, r_s1.corner_c};
        o_entry.fa     = {1'b0, r_s1.corner_a} + r_vcount;
        o_entry.fb     = {1'b0, r_s1.corner_b} + r_vcount;
        o_entry.fc     = {1'b0, r_s1.corner_c} + r_vcount;
        o_entry.neg    = w_dot[49];
        o_entry.mask   = r_s1.open_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vseen <= '0;
        end else if (o_push) begin
            if (r_s1.req == svx_pkg::REQ_VERTEX) begin
                r_vseen <= r_vseen + svx_pkg::IDX_W'(1);
            end else if (r_s1.req == svx_pkg::REQ_FINISH) begin
                r_vseen <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/svx_queue.sv -----
// ----------------------------------------------------------------------------
// svx_queue
// short flip-flop queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module svx_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rdata   = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/svx_back.sv -----
// ----------------------------------------------------------------------------
// svx_back
// sequences the result words of each queued item into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module svx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  svx_pkg::t_entry i_q_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output svx_pkg::t_res   o_res
);

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_SIDE_A = 4'b0100,
        PH_SIDE_B = 4'b1000
    } t_phase;

    logic            r_busy;
    svx_pkg::t_entry r_ent;
    t_phase          r_ph, n_ph;
    logic [2:0]      r_rem, n_rem;
    logic [svx_pkg::IDX_W-1:0] r_tris;
    logic            r_o_valid;
    svx_pkg::t_res   r_o;

    svx_pkg::t_res   w_res;
    logic            w_last, w_load, w_emit;
    logic [2:0]      w_rem_low;
    logic [svx_pkg::IDX_W-1:0] w_p, w_q, w_pf, w_qf;

    assign w_load    = !r_o_valid || i_ready;
    assign w_emit    = r_busy && w_load;
    assign w_rem_low = r_rem & (r_rem - 3'd1);
    assign o_pop     = i_q_valid && (!r_busy || (w_emit && w_last));
    assign o_valid   = r_o_valid;
    assign o_res     = r_o;

    // lowest open edge still to do
    always_comb begin
        if (r_rem[0]) begin
            w_p = r_ent.a;  w_q = r_ent.b;  w_pf = r_ent.fa; w_qf = r_ent.fb;
        end else if (r_rem[1]) begin
            w_p = r_ent.b;  w_q = r_ent.c;  w_pf = r_ent.fb; w_qf = r_ent.fc;
        end else begin
            w_p = r_ent.c;  w_q = r_ent.a;  w_pf = r_ent.fc; w_qf = r_ent.fa;
        end
    end

    always_comb begin
        w_res  = '0;
        w_last = 1'b0;
        n_ph   = r_ph;
        n_rem  = r_rem;
        case (r_ent.kind)
            svx_pkg::REQ_VERTEX: begin
                if (r_ph == PH_FIRST) begin
                    w_res.kind      = svx_pkg::KIND_NEAR;
                    w_res.vert_slot = r_ent.slot_n;
                    w_res.vx        = r_ent.near_x;
                    w_res.vy        = r_ent.near_y;
                    w_res.vz        = r_ent.near_z;
                end else begin
                    w_res.kind      = svx_pkg::KIND_FAR;
                    w_res.vert_slot = r_ent.slot_f;
                    w_res.vx        = r_ent.far_x;
                    w_res.vy        = r_ent.far_y;
                    w_res.vz        = r_ent.far_z;
                    w_last          = 1'b1;
                end
                n_ph = PH_SECOND;
            end
            svx_pkg::REQ_TRI: begin
                w_res.kind = svx_pkg::KIND_TRI;
                case (r_ph)
                    PH_FIRST: begin
                        if (r_ent.neg) begin
                            w_res.tri_i0 = r_ent.a;
                            w_res.tri_i1 = r_ent.b;
                            w_res.tri_i2 = r_ent.c;
                        end else begin
                            w_res.tri_i0 = r_ent.c;
                            w_res.tri_i1 = r_ent.b;
                            w_res.tri_i2 = r_ent.a;
                        end
                        n_ph = PH_SECOND;
                    end
                    PH_SECOND: begin
                        if (r_ent.neg) begin
                            w_res.tri_i0 = r_ent.fc;
                            w_res.tri_i1 = r_ent.fb;
                            w_res.tri_i2 = r_ent.fa;
                        end else begin
                            w_res.tri_i0 = r_ent.fa;
                            w_res.tri_i1 = r_ent.fb;
                            w_res.tri_i2 = r_ent.fc;
                        end
                        w_last = (r_rem == 3'd0);
                        n_ph   = PH_SIDE_A;
                    end
                    PH_SIDE_A: begin
                        if (r_ent.neg) begin
                            w_res.tri_i0 = w_qf;
                            w_res.tri_i1 = w_q;
                            w_res.tri_i2 = w_p;
                        end else begin
                            w_res.tri_i0 = w_p;
                            w_res.tri_i1 = w_q;
                            w_res.tri_i2 = w_qf;
                        end
                        n_ph = PH_SIDE_B;
                    end
                    PH_SIDE_B: begin
                        if (r_ent.neg) begin
                            w_res.tri_i0 = w_p;
                            w_res.tri_i1 = w_pf;
                            w_res.tri_i2 = w_qf;
                        end else begin
                            w_res.tri_i0 = w_qf;
                            w_res.tri_i1 = w_pf;
                            w_res.tri_i2 = w_p;
                        end
                        w_last = (w_rem_low == 3'd0);
                        n_rem  = w_rem_low;
                        n_ph   = PH_SIDE_A;
                    end
                    default: ;
                endcase
            end
            svx_pkg::REQ_FINISH: begin
                w_res.kind      = svx_pkg::KIND_TOTAL;
                w_res.tri_total = r_tris;
                w_last          = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
        w_res.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_FIRST;
            r_rem  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_ph   <= PH_FIRST;
            r_rem  <= i_q_entry.mask;
        end else if (w_emit) begin
            r_busy <= !w_last;
            r_ph   <= n_ph;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tris <= '0;
        end else if (w_emit) begin
            if (r_ent.kind == svx_pkg::REQ_FINISH) begin
                r_tris <= '0;
            end else if (r_ent.kind == svx_pkg::REQ_TRI && r_tris < svx_pkg::TRI_CAP) begin
                r_tris <= r_tris + svx_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o <= w_res;
        end
    end

endmodule

`default_nettype wire
